>>> hdl/bnpm_pkg.sv
// ----------------------------------------------------------------------------
// bnpm_pkg
// shared types and default constants for the binary node pdf merge block
// ----------------------------------------------------------------------------
package bnpm_pkg;

  localparam int MAX_SYMBOLS_DEF = 16;
  localparam int PROB_BITS_DEF   = 15;
  localparam int NODE_BITS_DEF   = 8;

  typedef struct packed {
    logic [7:0]  branch_prob;
    logic [15:0] src_prob;
    logic        last_in;
  } in_item_t;

  typedef struct packed {
    logic [4:0]  out_index;
    logic [15:0] out_prob;
    logic        last_out;
  } out_item_t;

  // controller to datapath
  typedef struct packed {
    logic accept;     // capture an input transfer
    logic mul;        // form the scaled product
    logic wr_load;    // write the rounded entry
    logic pass_init;  // start a pass over the table
    logic clamp;      // pass also clamps and sums
    logic rd_pass;    // issue a pass read
    logic rd_emit;    // issue an emit read
    logic adjust;     // apply one shortfall or excess step
    logic emit_init;  // rewind the entry pointer
    logic emit_ld;    // load the output register
    logic clear;      // table done
  } bnpm_cmd_t;

  // datapath to controller
  typedef struct packed {
    logic tbl_end;
    logic addr_last;
    logic mass_zero;
    logic out_free;
  } bnpm_sts_t;

endpackage

>>> hdl/bnpm_ctrl.sv
// ----------------------------------------------------------------------------
// bnpm_ctrl
// sequencer: load, clamp pass, adjust rounds and emit of the merged table
// ----------------------------------------------------------------------------
module bnpm_ctrl import bnpm_pkg::*; (
  input  logic      clk,
  input  logic      rst_n,
  input  logic      in_valid,
  output logic      in_stall,
  input  bnpm_sts_t sts,
  output bnpm_cmd_t cmd
);

  localparam logic [3:0] ST_IDLE    = 4'd0;
  localparam logic [3:0] ST_MUL     = 4'd1;
  localparam logic [3:0] ST_WR      = 4'd2;
  localparam logic [3:0] ST_PINIT_C = 4'd3;
  localparam logic [3:0] ST_PINIT_S = 4'd4;
  localparam logic [3:0] ST_PRD     = 4'd5;
  localparam logic [3:0] ST_PDRN    = 4'd6;
  localparam logic [3:0] ST_DECIDE  = 4'd7;
  localparam logic [3:0] ST_ADJ     = 4'd8;
  localparam logic [3:0] ST_ADJCHK  = 4'd9;
  localparam logic [3:0] ST_EMRD    = 4'd10;
  localparam logic [3:0] ST_EMLD    = 4'd11;

  logic [3:0] state_r, state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  assign in_stall = (state_r != ST_IDLE);

  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    unique case (state_r)
      ST_IDLE: begin
        if (in_valid) begin
          cmd.accept = 1'b1;
          state_nxt  = ST_MUL;
        end
      end
      ST_MUL: begin
        cmd.mul   = 1'b1;
        state_nxt = ST_WR;
      end
      ST_WR: begin
        cmd.wr_load = 1'b1;
        state_nxt   = sts.tbl_end ? ST_PINIT_C : ST_IDLE;
      end
      ST_PINIT_C: begin
        cmd.pass_init = 1'b1;
        cmd.clamp     = 1'b1;
        state_nxt     = ST_PRD;
      end
      ST_PINIT_S: begin
        cmd.pass_init = 1'b1;
        state_nxt     = ST_PRD;
      end
      ST_PRD: begin
        cmd.rd_pass = 1'b1;
        if (sts.addr_last) begin
          state_nxt = ST_PDRN;
        end
      end
      ST_PDRN: begin
        state_nxt = ST_DECIDE;
      end
      ST_DECIDE: begin
        if (sts.mass_zero) begin
          cmd.emit_init = 1'b1;
          state_nxt     = ST_EMRD;
        end else begin
          state_nxt = ST_ADJ;
        end
      end
      ST_ADJ: begin
        cmd.adjust = 1'b1;
        state_nxt  = ST_ADJCHK;
      end
      ST_ADJCHK: begin
        // excess left over: rescan for the new largest entry
        if (sts.mass_zero) begin
          cmd.emit_init = 1'b1;
          state_nxt     = ST_EMRD;
        end else begin
          state_nxt = ST_PINIT_S;
        end
      end
      ST_EMRD: begin
        cmd.rd_emit = 1'b1;
        state_nxt   = ST_EMLD;
      end
      ST_EMLD: begin
        if (sts.out_free) begin
          cmd.emit_ld = 1'b1;
          if (sts.addr_last) begin
            cmd.clear = 1'b1;
            state_nxt = ST_IDLE;
          end else begin
            state_nxt = ST_EMRD;
          end
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

endmodule

>>> hdl/bnpm_dp.sv
// ----------------------------------------------------------------------------
// bnpm_dp
// datapath: scaling multiplier, table memory, clamp and argmax pass,
// mass adjust and output register
// ----------------------------------------------------------------------------
module bnpm_dp import bnpm_pkg::*; #(
  parameter int MAX_SYMBOLS = MAX_SYMBOLS_DEF,
  parameter int PROB_BITS   = PROB_BITS_DEF,
  parameter int NODE_BITS   = NODE_BITS_DEF
) (
  input  logic      clk,
  input  logic      rst_n,
  input  in_item_t  in_data,
  input  bnpm_cmd_t cmd,
  output bnpm_sts_t sts,
  output logic      out_valid,
  input  logic      out_stall,
  output out_item_t out_data
);

  localparam int CNT_W  = $clog2(MAX_SYMBOLS + 1);
  localparam int ENT_W  = (PROB_BITS + 1 > 16) ? PROB_BITS + 1 : 16;
  localparam int MASS_W = PROB_BITS + $clog2(MAX_SYMBOLS + 2) + 2;
  localparam int PW     = NODE_BITS + 1 + 16;
  localparam int DEPTH  = MAX_SYMBOLS + 1;

  localparam logic [ENT_W-1:0]     TOTAL_E = {{(ENT_W-1){1'b0}}, 1'b1} << PROB_BITS;
  localparam logic [MASS_W-1:0]    TOTAL_M = {{(MASS_W-1){1'b0}}, 1'b1} << PROB_BITS;
  localparam logic [NODE_BITS:0]   SCALE   = {1'b1, {NODE_BITS{1'b0}}};
  localparam logic [PW:0]          ROUND   = {{(PW-NODE_BITS+1){1'b0}}, 1'b1,
                                              {(NODE_BITS-1){1'b0}}};

  logic [ENT_W-1:0] mem [DEPTH];

  logic [NODE_BITS-1:0]     held_r;
  logic [ENT_W-1:0]         t0_r;
  logic [15:0]              src_r;
  logic                     last_r;
  logic [CNT_W-1:0]         cnt_r;
  logic [PW-1:0]            product_r;
  logic signed [MASS_W-1:0] mass_r;
  logic [CNT_W-1:0]         addr_r;
  logic [ENT_W-1:0]         rd_data_r;
  logic                     pv_r;
  logic [CNT_W-1:0]         pk_r;
  logic                     clamp_r;
  logic [ENT_W-1:0]         max1_r, max2_r;
  logic [CNT_W-1:0]         idx_r;
  logic                     out_valid_r;
  out_item_t                out_item_r;

  logic [NODE_BITS-1:0] node_m;
  logic [PW:0]          rsum;
  logic [ENT_W-1:0]     load_val;
  logic [ENT_W-1:0]     upper;
  logic [ENT_W-1:0]     v_clamp;
  logic [ENT_W-1:0]     v_sel;
  logic                 mass_neg;
  logic [MASS_W-1:0]    neg_mass;
  logic [ENT_W-1:0]     gap;
  logic [ENT_W-1:0]     gap1;
  logic [MASS_W-1:0]    step_ext;
  logic [MASS_W-1:0]    step;
  logic [ENT_W-1:0]     adj_new;
  logic                 mem_we;
  logic [CNT_W-1:0]     mem_wa;
  logic [ENT_W-1:0]     mem_wd;

  assign node_m   = in_data.branch_prob[NODE_BITS-1:0];
  assign rsum     = {1'b0, product_r} + ROUND;
  assign load_val = ENT_W'(rsum >> NODE_BITS);

  // clamp to 1 .. 2^PROB_BITS - n
  assign upper   = TOTAL_E - ENT_W'(cnt_r);
  assign v_clamp = (rd_data_r > upper) ? upper :
                   (rd_data_r == '0) ? {{(ENT_W-1){1'b0}}, 1'b1} : rd_data_r;
  assign v_sel   = clamp_r ? v_clamp : rd_data_r;

  // one adjust step: whole shortfall, or excess down to the runner-up (one on a tie) within the excess
  assign mass_neg = mass_r[MASS_W-1];
  assign neg_mass = MASS_W'(-mass_r);
  assign gap      = max1_r - max2_r;
  assign gap1     = (gap == '0) ? {{(ENT_W-1){1'b0}}, 1'b1} : gap;
  assign step_ext = MASS_W'(gap1);
  assign step     = (step_ext > neg_mass) ? neg_mass : step_ext;
  assign adj_new  = mass_neg ? (max1_r - ENT_W'(step)) : (max1_r + ENT_W'(mass_r));

  always_comb begin
    mem_we = 1'b0;
    mem_wa = cnt_r;
    mem_wd = load_val;
    if (cmd.wr_load) begin
      mem_we = 1'b1;
    end else if (pv_r && clamp_r) begin
      mem_we = 1'b1;
      mem_wa = pk_r;
      mem_wd = v_clamp;
    end else if (cmd.adjust && (idx_r != '0)) begin
      mem_we = 1'b1;
      mem_wa = idx_r;
      mem_wd = adj_new;
    end
  end

  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[mem_wa] <= mem_wd;
    end
    if (cmd.rd_pass || cmd.rd_emit) begin
      rd_data_r <= mem[addr_r];
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    if (cmd.accept) begin
      src_r  <= in_data.src_prob;
      last_r <= in_data.last_in;
      if (cnt_r == '0) begin
        t0_r <= ENT_W'(node_m) << (PROB_BITS - NODE_BITS);
      end
    end
    if (cmd.mul) begin
      product_r <= PW'(SCALE - {1'b0, held_r}) * PW'(src_r);
    end
    if (cmd.rd_pass) begin
      pk_r <= addr_r;
    end
    if (cmd.pass_init) begin
      clamp_r <= cmd.clamp;
    end
    if (cmd.adjust && (idx_r == '0)) begin
      t0_r <= adj_new;
    end
    if (cmd.emit_ld) begin
      out_item_r.out_index <= 5'(addr_r);
      out_item_r.out_prob  <= 16'((addr_r == '0) ? t0_r : rd_data_r);
      out_item_r.last_out  <= (addr_r == cnt_r);
    end
  end

  // control and running state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      held_r      <= '0;
      cnt_r       <= '0;
      mass_r      <= $signed(TOTAL_M);
      addr_r      <= '0;
      pv_r        <= 1'b0;
      max1_r      <= '0;
      max2_r      <= '0;
      idx_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      pv_r <= cmd.rd_pass;
      if (cmd.accept) begin
        cnt_r <= cnt_r + 1'b1;
        if (cnt_r == '0) begin
          held_r <= node_m;
        end
      end
      if (cmd.pass_init) begin
        addr_r <= {{(CNT_W-1){1'b0}}, 1'b1};
        max1_r <= t0_r;
        max2_r <= '0;
        idx_r  <= '0;
        if (cmd.clamp) begin
          mass_r <= $signed(TOTAL_M - MASS_W'(t0_r));
        end
      end
      if (cmd.rd_pass || cmd.emit_ld) begin
        addr_r <= addr_r + 1'b1;
      end
      if (cmd.emit_init) begin
        addr_r <= '0;
      end
      if (pv_r) begin
        // lowest index wins ties, equal values still feed the runner-up
        if (v_sel > max1_r) begin
          max2_r <= max1_r;
          max1_r <= v_sel;
          idx_r  <= pk_r;
        end else if (v_sel > max2_r) begin
          max2_r <= v_sel;
        end
        if (clamp_r) begin
          mass_r <= mass_r - $signed(MASS_W'(v_clamp));
        end
      end
      if (cmd.adjust) begin
        mass_r <= mass_neg ? (mass_r + $signed(step)) : '0;
      end
      if (cmd.clear) begin
        cnt_r  <= '0;
        mass_r <= $signed(TOTAL_M);
      end
      if (cmd.emit_ld) begin
        out_valid_r <= 1'b1;
      end else if (out_valid_r && !out_stall) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  assign sts.tbl_end   = last_r || (cnt_r == CNT_W'(MAX_SYMBOLS));
  assign sts.addr_last = (addr_r == cnt_r);
  assign sts.mass_zero = (mass_r == '0);
  assign sts.out_free  = !out_valid_r || !out_stall;

  assign out_valid = out_valid_r;
  assign out_data  = out_item_r;

  a_cnt_range: assert property (@(posedge clk) disable iff (!rst_n)
    cnt_r <= CNT_W'(MAX_SYMBOLS))
    else $error("symbol count beyond table size");

  a_pass_addr: assert property (@(posedge clk) disable iff (!rst_n)
    pv_r |-> (pk_r != '0) && (pk_r <= cnt_r))
    else $error("pass read outside loaded entries");

  a_max_order: assert property (@(posedge clk) disable iff (!rst_n)
    max1_r >= max2_r)
    else $error("runner-up above largest entry");

  a_emit_nonneg: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.emit_init |-> mass_r == '0)
    else $error("emit started with mass left over");

endmodule

>>> hdl/binary_node_pdf_merge.sv
// ----------------------------------------------------------------------------
// binary_node_pdf_merge
// merges a binary node probability with a symbol probability table
//
//   channel | ports                          | moves
//   --------+--------------------------------+-----------------------------
//   input   | in_valid, in_stall, in_data    | one source symbol per transfer
//   output  | out_valid, out_stall, out_data | one merged entry per transfer
//
// a source symbol goes through capture, multiply and write into the table.
// at the end of a table of n symbols: clamp and argmax pass, then adjust
// rounds while mass is left over (an excess is cut round by round, each with
// a new pass, one table entry a cycle); emit then takes entries in turn.
// reset (synchronous, rst_n low) clears count and handshake state; the table
// memory needs no clearing pass. out_stall only holds the emit sequence.
// ----------------------------------------------------------------------------
module binary_node_pdf_merge import bnpm_pkg::*; #(
  parameter int MAX_SYMBOLS = MAX_SYMBOLS_DEF,
  parameter int PROB_BITS   = PROB_BITS_DEF,
  parameter int NODE_BITS   = NODE_BITS_DEF
) (
  input  logic      clk,
  input  logic      rst_n,
  input  logic      in_valid,
  output logic      in_stall,
  input  in_item_t  in_data,
  output logic      out_valid,
  input  logic      out_stall,
  output out_item_t out_data
);

  bnpm_cmd_t cmd;
  bnpm_sts_t sts;

  bnpm_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .sts      (sts),
    .cmd      (cmd)
  );

  bnpm_dp #(
    .MAX_SYMBOLS (MAX_SYMBOLS),
    .PROB_BITS   (PROB_BITS),
    .NODE_BITS   (NODE_BITS)
  ) u_dp (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_data   (in_data),
    .cmd       (cmd),
    .sts       (sts),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data)
  );

endmodule

>>> bench/pdf_merge_checker.sv
// ----------------------------------------------------------------------------
// pdf_merge_checker
// watches both channels of the pdf merge block, keeps its own copy of the
// table state, predicts every merged entry and compares field by field
// ----------------------------------------------------------------------------
module pdf_merge_checker import bnpm_pkg::*; (
  input  logic      clk,
  input  logic      rst_n,
  input  logic      in_valid,
  input  logic      in_stall,
  input  in_item_t  in_data,
  input  logic      out_valid,
  input  logic      out_stall,
  input  out_item_t out_data,
  input  logic      run_done,
  output int        pending_results,
  output int        mismatch_cnt
);

  localparam int unsigned TOTAL_MASS = 1 << PROB_BITS_DEF;
  localparam int unsigned NODE_SCALE = 1 << NODE_BITS_DEF;
  localparam int          PRINT_CAP  = 60;

  int unsigned tbl [0:MAX_SYMBOLS_DEF];
  int unsigned sym_cnt;
  int unsigned node_held;
  out_item_t   merged_q [$];
  out_item_t   want;
  bit          tail_checked;

  initial begin
    mismatch_cnt    = 0;
    pending_results = 0;
    sym_cnt         = 0;
    node_held       = 0;
    tail_checked    = 1'b0;
  end

  task automatic report_mismatch(input string msg);
    if (mismatch_cnt < PRINT_CAP)
      $display("[%0t] mismatch: %s", $time, msg);
    mismatch_cnt++;
  endtask

  // lowest index wins a tie
  function automatic int unsigned largest_entry(input int unsigned n);
    int unsigned best;
    int unsigned k;
    best = 0;
    for (k = 1; k <= n; k++)
      if (tbl[k] > tbl[best])
        best = k;
    return best;
  endfunction

  task automatic merge_symbol(input in_item_t it);
    int unsigned n;
    int unsigned k;
    int unsigned top;
    longint      upper;
    longint      mass;
    longint      p;
    longint      second;
    longint      step;
    out_item_t   e;
    if (sym_cnt == 0) begin
      node_held = it.branch_prob;
      tbl[0]    = node_held << (PROB_BITS_DEF - NODE_BITS_DEF);
    end
    if (sym_cnt >= MAX_SYMBOLS_DEF)
      sym_cnt = MAX_SYMBOLS_DEF - 1;
    sym_cnt++;
    tbl[sym_cnt] = ((NODE_SCALE - node_held) * it.src_prob + NODE_SCALE / 2) >> NODE_BITS_DEF;
    if (!it.last_in && sym_cnt < MAX_SYMBOLS_DEF)
      return;

    n     = sym_cnt;
    upper = TOTAL_MASS - n;
    mass  = TOTAL_MASS - tbl[0];
    for (k = 1; k <= n; k++) begin
      p = tbl[k];
      if (p > upper)
        p = upper;
      if (p < 1)
        p = 1;
      tbl[k] = p;
      mass   = mass - p;
    end

    if (mass > 0) begin
      top      = largest_entry(n);
      tbl[top] = tbl[top] + mass;
    end else begin
      // a strictly largest entry drops to the runner-up level, or by the excess if less
      while (mass < 0) begin
        top    = largest_entry(n);
        second = 0;
        for (k = 0; k <= n; k++)
          if (k != top && tbl[k] > second)
            second = tbl[k];
        step = tbl[top];
        step = step - second;
        if (step == 0)
          step = 1;
        if (step > -mass)
          step = -mass;
        tbl[top] = tbl[top] - step;
        mass     = mass + step;
      end
    end

    for (k = 0; k <= n; k++) begin
      e.out_index = k[4:0];
      e.out_prob  = tbl[k][15:0];
      e.last_out  = (k == n);
      merged_q.push_back(e);
    end
    sym_cnt = 0;
  endtask

  always @(posedge clk) begin
    if (!rst_n) begin
      sym_cnt   = 0;
      node_held = 0;
      merged_q.delete();
    end else begin
      if (in_valid && !in_stall)
        merge_symbol(in_data);
      if (out_valid && !out_stall) begin
        if (merged_q.size() == 0) begin
          report_mismatch($sformatf("entry %0d (prob %0d) with nothing expected",
                                    out_data.out_index, out_data.out_prob));
        end else begin
          want = merged_q.pop_front();
          if (out_data.out_index !== want.out_index)
            report_mismatch($sformatf("out_index %0d, expected %0d",
                                      out_data.out_index, want.out_index));
          if (out_data.out_prob !== want.out_prob)
            report_mismatch($sformatf("entry %0d out_prob %0d, expected %0d",
                                      want.out_index, out_data.out_prob, want.out_prob));
          if (out_data.last_out !== want.last_out)
            report_mismatch($sformatf("entry %0d last_out %b, expected %b",
                                      want.out_index, out_data.last_out, want.last_out));
        end
      end
      if (run_done && !tail_checked) begin
        tail_checked = 1'b1;
        if (merged_q.size() != 0)
          report_mismatch($sformatf("%0d merged entries never came out", merged_q.size()));
      end
    end
    pending_results <= merged_q.size();
  end

endmodule

>>> bench/tb_top.sv
// ----------------------------------------------------------------------------
// tb_top
// stimulus and verdict for the binary node pdf merge block: directed corner
// tables, then random tables under three idle/stall mixes, with one long
// output hold-off and two full drains; the checker does all comparing
// ----------------------------------------------------------------------------
module tb_top;
  import bnpm_pkg::*;

  localparam int HOLD_CYCLES = 400;
  localparam int DRAIN_LIMIT = 400000;
  localparam int TAIL_CYCLES = 64;
  localparam int PHASE_ITEMS = 55;

  logic      clk;
  logic      rst_n;
  logic      in_valid;
  logic      in_stall;
  in_item_t  in_data;
  logic      out_valid;
  logic      out_stall;
  out_item_t out_data;
  logic      run_done;
  logic      hold_req;
  bit        hold_done;

  int unsigned send_idle_pct;
  int unsigned recv_stall_pct;
  int unsigned sym_sent;
  int          pending_results;
  int          mismatch_cnt;

  binary_node_pdf_merge dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data)
  );

  pdf_merge_checker chk (
    .clk             (clk),
    .rst_n           (rst_n),
    .in_valid        (in_valid),
    .in_stall        (in_stall),
    .in_data         (in_data),
    .out_valid       (out_valid),
    .out_stall       (out_stall),
    .out_data        (out_data),
    .run_done        (run_done),
    .pending_results (pending_results),
    .mismatch_cnt    (mismatch_cnt)
  );

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  initial begin
    #16000000;
    $display("CHECKS FAILED");
    $finish;
  end

  // result side: random stall, plus one long hold-off on request
  initial begin
    hold_done = 1'b0;
    out_stall <= 1'b0;
    forever begin
      @(posedge clk);
      if (hold_req && !hold_done) begin
        hold_done = 1'b1;
        out_stall <= 1'b1;
        repeat (HOLD_CYCLES) @(posedge clk);
      end
      out_stall <= ($urandom_range(0, 99) < recv_stall_pct);
    end
  end

  // valid stays high straight into the next transfer when no gap is drawn
  task automatic send_item(input logic [7:0] node, input logic [15:0] src, input logic last);
    in_item_t it;
    it.branch_prob = node;
    it.src_prob    = src;
    it.last_in     = last;
    while ($urandom_range(0, 99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data  <= it;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    sym_sent++;
  endtask

  task automatic run_phase(input int unsigned s_pct, input int unsigned r_pct,
                           input int unsigned n_items);
    int unsigned kind;
    int unsigned n;
    int unsigned k;
    int unsigned rem;
    int unsigned v;
    int unsigned big_pos;
    int unsigned stop;
    logic [7:0]  node;
    send_idle_pct = s_pct;
    recv_stall_pct <= r_pct;
    stop = sym_sent + n_items;
    while (sym_sent < stop) begin
      kind = $urandom_range(0, 9);
      node = 8'($urandom_range(0, 255));
      if (kind < 7) begin
        // well-formed table: source mass adds up to the full scale
        n   = ($urandom_range(0, 3) == 0) ? $urandom_range(7, MAX_SYMBOLS_DEF)
                                          : $urandom_range(1, 6);
        rem = 1 << PROB_BITS_DEF;
        for (k = 1; k <= n; k++) begin
          if (k == n) begin
            v = rem;
          end else begin
            v = $urandom_range(0, 2 * rem / (n - k + 1));
            if (v > rem)
              v = rem;
          end
          rem = rem - v;
          send_item(node, v[15:0], k == n);
          node = 8'($urandom_range(0, 255));
        end
      end else if (kind < 9) begin
        // one arbitrary source value, the rest kept light so the excess stays short
        n       = $urandom_range(1, 4);
        big_pos = $urandom_range(1, n);
        for (k = 1; k <= n; k++) begin
          v = (k == big_pos) ? $urandom_range(0, 65535) : $urandom_range(0, 255);
          send_item(node, v[15:0], k == n);
          node = 8'($urandom_range(0, 255));
        end
      end else begin
        // overlong run: the block closes the table itself at the symbol limit
        n = $urandom_range(MAX_SYMBOLS_DEF + 1, MAX_SYMBOLS_DEF + 6);
        for (k = 1; k <= n; k++) begin
          v = $urandom_range(0, 2047);
          send_item(node, v[15:0], k == n);
          node = 8'($urandom_range(0, 255));
        end
      end
    end
  endtask

  initial begin
    int unsigned drain;
    int unsigned k;
    rst_n    <= 1'b0;
    in_valid <= 1'b0;
    in_data  <= '0;
    run_done <= 1'b0;
    hold_req <= 1'b0;
    recv_stall_pct <= 78;
    send_idle_pct = 38;
    sym_sent      = 0;
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;

    // field extremes, one symbol each
    send_item(8'hFF, 16'hFFFF, 1'b1);
    send_item(8'h00, 16'h0000, 1'b1);
    // zero node probability keeps the sources at full weight
    send_item(8'h00, 16'd16384, 1'b0);
    send_item(8'hAA, 16'd16384, 1'b1);
    // source above full scale hits the upper clamp, zero source the lower one
    send_item(8'h00, 16'd40000, 1'b0);
    send_item(8'h55, 16'd0, 1'b1);
    // tied entries: shortfall to the lower index, then excess shared on a tie
    send_item(8'd64, 16'd10923, 1'b1);
    send_item(8'd129, 16'd33284, 1'b1);
    // table too long: no last flag, closed by the symbol limit
    for (k = 0; k < MAX_SYMBOLS_DEF; k++)
      send_item((k == 0) ? 8'd128 : 8'(k), 16'd2048, 1'b0);

    run_phase(38, 78, PHASE_ITEMS);

    // sender rests until every merged entry is out
    in_valid <= 1'b0;
    @(posedge clk);
    while (pending_results != 0) @(posedge clk);

    run_phase(78, 38, PHASE_ITEMS);

    hold_req <= 1'b1;
    run_phase(0, 0, PHASE_ITEMS);

    in_valid <= 1'b0;
    @(posedge clk);
    drain = 0;
    while (pending_results != 0 && drain < DRAIN_LIMIT) begin
      @(posedge clk);
      drain++;
    end
    repeat (TAIL_CYCLES) @(posedge clk);
    run_done <= 1'b1;
    repeat (2) @(posedge clk);

    if (mismatch_cnt == 0)
      $display("ALL CHECKS PASSED");
    else
      $display("CHECKS FAILED");
    $finish;
  end

endmodule

>>> files.f
hdl/bnpm_pkg.sv
hdl/bnpm_ctrl.sv
hdl/bnpm_dp.sv
hdl/binary_node_pdf_merge.sv
bench/pdf_merge_checker.sv
bench/tb_top.sv
